>>> hdl/triangle_plane_split_macros.svh
// Assertion macros used by the triangle plane split back end.
`ifndef TRIANGLE_PLANE_SPLIT_MACROS_SVH
`define TRIANGLE_PLANE_SPLIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPS_ASSERT(label, clk, rst_n, prop)
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tps_pkg.sv
// Package with types, constants and register codes of the triangle plane split.
`default_nettype none
package tps_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NORM_FRAC       = 14;
    localparam int ALPHA_FRAC      = 30;
    localparam int CFG_IDX_W       = 3;
    localparam int DIST_W          = 64;

    typedef enum logic [2:0] {
        REG_NX   = 3'd0,
        REG_NY   = 3'd1,
        REG_NZ   = 3'd2,
        REG_OFF  = 3'd3,
        REG_BAND = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_SPLIT    = 3'd0,
        ST_BELOW    = 3'd1,
        ST_ABOVE    = 3'd2,
        ST_COP_SAME = 3'd3,
        ST_COP_OPP  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SIDE_ON    = 2'd0,
        SIDE_BELOW = 2'd1,
        SIDE_ABOVE = 2'd2
    } side_t;

    typedef enum logic [1:0] {
        KIND_WHOLE = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_DIV   = 2'd1,
        BK_LERP  = 2'd2,
        BK_EMIT  = 2'd3
    } back_state_t;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [31:0] off;
        logic [15:0] band;
    } plane_cfg_t;
endpackage
`default_nettype wire

>>> hdl/tps_if.sv
// Valid/ready channel interfaces for triangles, pieces and configuration writes.
`default_nettype none
interface tps_tri_if #(parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic signed [15:0] face_normal_x, face_normal_y, face_normal_z;
    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    face_normal_x, face_normal_y, face_normal_z, input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  face_normal_x, face_normal_y, face_normal_z, output ready);
endinterface

interface tps_piece_if #(parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] out_v0_x, out_v0_y, out_v0_z;
    logic signed [COORD_WIDTH-1:0] out_v1_x, out_v1_y, out_v1_z;
    logic signed [COORD_WIDTH-1:0] out_v2_x, out_v2_y, out_v2_z;
    logic upper_side;
    logic [2:0] status;
    logic last_piece;
    modport source (output valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y,
                    out_v1_z, out_v2_x, out_v2_y, out_v2_z, upper_side, status,
                    last_piece, input ready);
    modport sink (input valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y,
                  out_v1_z, out_v2_x, out_v2_y, out_v2_z, upper_side, status,
                  last_piece, output ready);
endinterface

interface tps_cfg_if;
    logic valid;
    logic ready;
    logic [tps_pkg::CFG_IDX_W-1:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/tps_front.sv
// Front end: plane distance per vertex, side classification and item kind.
`default_nettype none
module tps_front #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire tps_pkg::plane_cfg_t cfg,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [9*COORD_WIDTH-1:0] in_verts,
    input  wire logic [47:0] in_fn,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [9*COORD_WIDTH-1:0] out_verts,
    output logic [3*tps_pkg::DIST_W-1:0] out_dist,
    output logic [5:0] out_sides,
    output tps_pkg::kind_t out_kind,
    output tps_pkg::status_t out_status
);
    localparam int DW = tps_pkg::DIST_W;
    localparam int PW = COORD_WIDTH + 16;

    // Stage 1: products. Stage 2: distances and classification.
    logic s1_valid_reg, s2_valid_reg;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [33:0] fdot_reg;
    logic [9*COORD_WIDTH-1:0] s1_verts_reg, s2_verts_reg;
    logic [3*DW-1:0] s2_dist_reg;
    logic [5:0] s2_sides_reg;
    tps_pkg::kind_t s2_kind_reg;
    tps_pkg::status_t s2_status_reg;
    logic s1_adv, s2_adv;

    assign s2_adv = !s2_valid_reg || out_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    logic signed [15:0] nsel [3];
    assign nsel[0] = cfg.nx;
    assign nsel[1] = cfg.ny;
    assign nsel[2] = cfg.nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= PW'($signed(in_verts[i*COORD_WIDTH +: COORD_WIDTH]))
                               * PW'(nsel[i%3]);
            fdot_reg <= 34'($signed(in_fn[15:0])) * 34'($signed(cfg.nx))
                      + 34'($signed(in_fn[31:16])) * 34'($signed(cfg.ny))
                      + 34'($signed(in_fn[47:32])) * 34'($signed(cfg.nz));
            s1_verts_reg <= in_verts;
        end
    end

    logic signed [DW-1:0] vert_dist [3];
    logic signed [DW-1:0] band_w;
    logic [1:0] side [3];
    logic any_above, any_below;
    always_comb
    begin
        band_w = DW'({cfg.band, {tps_pkg::NORM_FRAC{1'b0}}});
        any_above = 1'b0;
        any_below = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            vert_dist[i] = DW'(prod_reg[3*i]) + DW'(prod_reg[3*i+1]) + DW'(prod_reg[3*i+2])
                         + (DW'($signed(cfg.off)) <<< tps_pkg::NORM_FRAC);
            if (vert_dist[i] > band_w)
            begin
                side[i] = tps_pkg::SIDE_ABOVE;
                any_above = 1'b1;
            end
            else if (vert_dist[i] < -band_w)
            begin
                side[i] = tps_pkg::SIDE_BELOW;
                any_below = 1'b1;
            end
            else
                side[i] = tps_pkg::SIDE_ON;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_verts_reg <= s1_verts_reg;
            s2_dist_reg  <= {vert_dist[2], vert_dist[1], vert_dist[0]};
            s2_sides_reg <= {side[2], side[1], side[0]};
            if (any_above && any_below)
            begin
                s2_status_reg <= tps_pkg::ST_SPLIT;
                s2_kind_reg <= (side[0] == tps_pkg::SIDE_ON || side[1] == tps_pkg::SIDE_ON
                                || side[2] == tps_pkg::SIDE_ON)
                               ? tps_pkg::KIND_TWO : tps_pkg::KIND_THREE;
            end
            else
            begin
                s2_kind_reg <= tps_pkg::KIND_WHOLE;
                if (any_below) s2_status_reg <= tps_pkg::ST_BELOW;
                else if (any_above) s2_status_reg <= tps_pkg::ST_ABOVE;
                else if (fdot_reg < 0) s2_status_reg <= tps_pkg::ST_COP_OPP;
                else s2_status_reg <= tps_pkg::ST_COP_SAME;
            end
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_verts  = s2_verts_reg;
    assign out_dist   = s2_dist_reg;
    assign out_sides  = s2_sides_reg;
    assign out_kind   = s2_kind_reg;
    assign out_status = s2_status_reg;
endmodule
`default_nettype wire

>>> hdl/tps_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module tps_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic push, pop;

    assign in_ready = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end
endmodule
`default_nettype wire

>>> hdl/tps_back.sv
// Back end: crossing points, diagonal choice and piece emission.
`default_nettype none
`include "triangle_plane_split_macros.svh"
module tps_back #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [9*COORD_WIDTH-1:0] in_verts,
    input  wire logic [3*tps_pkg::DIST_W-1:0] in_dist,
    input  wire logic [5:0] in_sides,
    input  wire tps_pkg::kind_t in_kind,
    input  wire tps_pkg::status_t in_status,
    tps_piece_if.source res
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = tps_pkg::DIST_W;
    localparam int AF = tps_pkg::ALPHA_FRAC;
    localparam int CNTW = $clog2(AF + 1);
    localparam int SQW = 2 * (CW + 1) + 2;

    typedef logic signed [CW-1:0] vec_t [3];

    tps_pkg::back_state_t state_reg, state_next;
    vec_t v_reg [3];
    vec_t p_reg [2];
    logic [5:0] sides_reg;
    tps_pkg::kind_t kind_reg;
    tps_pkg::status_t status_reg;
    logic [DW-1:0] dmag_reg [3];
    logic [1:0] c_reg;
    logic which_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [AF-1:0] q_reg;
    logic [AF-1:0] alpha_reg [2];
    logic [CNTW-1:0] cnt_reg;
    logic [1:0] lcnt_reg;
    logic first_shorter_reg;
    logic [1:0] piece_reg, npieces;

    logic out_valid_reg;
    vec_t o_reg [3];
    logic o_upper_reg, o_last_reg;
    logic [2:0] o_status_reg;

    logic [1:0] side_of [3];
    assign side_of[0] = sides_reg[1:0];
    assign side_of[1] = sides_reg[3:2];
    assign side_of[2] = sides_reg[5:4];

    function automatic logic [1:0] nx3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    logic out_free;
    assign out_free = !out_valid_reg || res.ready;
    assign in_ready = state_reg == tps_pkg::BK_IDLE;
    assign npieces = (kind_reg == tps_pkg::KIND_WHOLE) ? 2'd1 :
                     (kind_reg == tps_pkg::KIND_TWO) ? 2'd2 : 2'd3;

    // Crossed edge selection on entry.
    logic [1:0] in_side [3];
    logic [1:0] in_c;
    logic cross_e [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++) in_side[i] = in_sides[2*i +: 2];
        for (int i = 0; i < 3; i++)
            cross_e[i] = in_side[i] != tps_pkg::SIDE_ON
                         && in_side[(i+1)%3] != tps_pkg::SIDE_ON
                         && in_side[i] != in_side[(i+1)%3];
        in_c = 2'd0;
        if (in_kind == tps_pkg::KIND_TWO)
        begin
            if (cross_e[0]) in_c = 2'd0;
            else if (cross_e[1]) in_c = 2'd1;
            else in_c = 2'd2;
        end
        else
        begin
            if (cross_e[0] && cross_e[1]) in_c = 2'd0;
            else if (cross_e[1] && cross_e[2]) in_c = 2'd1;
            else in_c = 2'd2;
        end
    end

    // Edge endpoints for the current crossing point.
    logic [1:0] ea, eb;
    assign ea = which_reg ? nx3(c_reg) : c_reg;
    assign eb = nx3(ea);

    // Lerp: one coordinate per cycle.
    logic signed [CW-1:0] la, lb;
    logic [CW:0] ldiff_w;
    logic ldiff_neg;
    logic [CW:0] ldmag;
    logic [CW+AF:0] lprod;
    logic [CW:0] lq;
    logic signed [CW-1:0] lres;
    always_comb
    begin
        la = v_reg[ea][lcnt_reg];
        lb = v_reg[eb][lcnt_reg];
        ldiff_w = (CW+1)'($signed(lb)) - (CW+1)'($signed(la));
        ldiff_neg = ldiff_w[CW];
        ldmag = ldiff_neg ? (CW+1)'(-$signed(ldiff_w)) : ldiff_w;
        lprod = (CW+AF+1)'(ldmag) * (CW+AF+1)'(alpha_reg[which_reg]);
        lq = (CW+1)'(lprod >> AF) + (CW+1)'(lprod[AF-1]);
        lres = ldiff_neg ? CW'(la - CW'(lq)) : CW'(la + CW'(lq));
    end

    // Squared length compare for the diagonal choice.
    logic [SQW-1:0] sq1, sq2;
    always_comb
    begin
        logic [CW:0] d1, d2, m1, m2;
        sq1 = '0;
        sq2 = '0;
        for (int k = 0; k < 3; k++)
        begin
            d1 = (CW+1)'($signed(p_reg[0][k])) - (CW+1)'($signed(v_reg[nx3(nx3(c_reg))][k]));
            d2 = (CW+1)'($signed(p_reg[1][k])) - (CW+1)'($signed(v_reg[c_reg][k]));
            m1 = d1[CW] ? (CW+1)'(-$signed(d1)) : d1;
            m2 = d2[CW] ? (CW+1)'(-$signed(d2)) : d2;
            sq1 = sq1 + SQW'(m1) * SQW'(m1);
            sq2 = sq2 + SQW'(m2) * SQW'(m2);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tps_pkg::BK_IDLE:
                if (in_valid)
                    state_next = (in_kind == tps_pkg::KIND_WHOLE)
                                 ? tps_pkg::BK_EMIT : tps_pkg::BK_DIV;
            tps_pkg::BK_DIV:
                if (cnt_reg == CNTW'(AF - 1)) state_next = tps_pkg::BK_LERP;
            tps_pkg::BK_LERP:
                if (lcnt_reg == 2'd2)
                    state_next = (which_reg || kind_reg == tps_pkg::KIND_TWO)
                                 ? tps_pkg::BK_EMIT : tps_pkg::BK_DIV;
            tps_pkg::BK_EMIT:
                if (out_free && piece_reg == npieces - 2'd1)
                    state_next = tps_pkg::BK_IDLE;
            default: state_next = tps_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tps_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tps_pkg::BK_EMIT && out_free) out_valid_reg <= 1'b1;
            else if (res.ready) out_valid_reg <= 1'b0;
        end
    end

    // Divider start values for the current edge.
    logic [DW-1:0] div_a, div_b;
    assign div_a = dmag_reg[which_reg ? nx3(c_reg) : c_reg];
    assign div_b = dmag_reg[which_reg ? nx3(nx3(c_reg)) : nx3(c_reg)];

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tps_pkg::BK_IDLE:
                if (in_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        for (int k = 0; k < 3; k++)
                            v_reg[i][k] <= in_verts[(3*i+k)*CW +: CW];
                        dmag_reg[i] <= in_dist[DW*i+DW-1]
                                       ? DW'(-$signed(in_dist[DW*i +: DW]))
                                       : in_dist[DW*i +: DW];
                    end
                    sides_reg <= in_sides;
                    kind_reg <= in_kind;
                    status_reg <= in_status;
                    c_reg <= in_c;
                    which_reg <= 1'b0;
                    cnt_reg <= '0;
                    lcnt_reg <= 2'd0;
                    piece_reg <= 2'd0;
                    q_reg <= '0;
                end
            tps_pkg::BK_DIV:
            begin
                logic [DW-1:0] r, den;
                if (cnt_reg == '0)
                begin
                    r = div_a;
                    den = div_a + div_b;
                end
                else
                begin
                    r = rem_reg;
                    den = den_reg;
                end
                den_reg <= den;
                if (r >= den - r)
                begin
                    rem_reg <= r - (den - r);
                    q_reg <= {q_reg[AF-2:0], 1'b1};
                    if (cnt_reg == CNTW'(AF - 1))
                        alpha_reg[which_reg] <= {q_reg[AF-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r + r;
                    q_reg <= {q_reg[AF-2:0], 1'b0};
                    if (cnt_reg == CNTW'(AF - 1))
                        alpha_reg[which_reg] <= {q_reg[AF-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            tps_pkg::BK_LERP:
            begin
                p_reg[which_reg][lcnt_reg] <= lres;
                if (lcnt_reg == 2'd2)
                begin
                    lcnt_reg <= 2'd0;
                    cnt_reg <= '0;
                    which_reg <= 1'b1;
                end
                else
                    lcnt_reg <= lcnt_reg + 2'd1;
            end
            tps_pkg::BK_EMIT:
            begin
                if (piece_reg == 2'd0 && kind_reg == tps_pkg::KIND_THREE)
                    first_shorter_reg <= sq1 < sq2;
                if (out_free) piece_reg <= piece_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // Piece assembly.
    logic [1:0] c1, c2;
    assign c1 = nx3(c_reg);
    assign c2 = nx3(c1);
    always_ff @(posedge clk)
    begin
        if (state_reg == tps_pkg::BK_EMIT && out_free)
        begin
            o_last_reg <= piece_reg == npieces - 2'd1;
            o_status_reg <= status_reg;
            case (kind_reg)
                tps_pkg::KIND_WHOLE:
                begin
                    o_reg <= v_reg;
                    o_upper_reg <= status_reg == tps_pkg::ST_ABOVE;
                end
                tps_pkg::KIND_TWO:
                    if (piece_reg == 2'd0)
                    begin
                        o_reg[0] <= p_reg[0];
                        o_reg[1] <= v_reg[c1];
                        o_reg[2] <= v_reg[c2];
                        o_upper_reg <= side_of[c1] == tps_pkg::SIDE_ABOVE;
                    end
                    else
                    begin
                        o_reg[0] <= p_reg[0];
                        o_reg[1] <= v_reg[c2];
                        o_reg[2] <= v_reg[c_reg];
                        o_upper_reg <= side_of[c_reg] == tps_pkg::SIDE_ABOVE;
                    end
                default:
                    if (piece_reg == 2'd0)
                    begin
                        o_reg[0] <= p_reg[0];
                        o_reg[1] <= v_reg[c1];
                        o_reg[2] <= p_reg[1];
                        o_upper_reg <= side_of[c1] == tps_pkg::SIDE_ABOVE;
                    end
                    else
                    begin
                        o_upper_reg <= side_of[c2] == tps_pkg::SIDE_ABOVE;
                        if (first_shorter_reg)
                        begin
                            o_reg[0] <= p_reg[0];
                            o_reg[1] <= (piece_reg == 2'd1) ? p_reg[1] : v_reg[c2];
                            o_reg[2] <= (piece_reg == 2'd1) ? v_reg[c2] : v_reg[c_reg];
                        end
                        else
                        begin
                            o_reg[0] <= (piece_reg == 2'd1) ? p_reg[0] : v_reg[c_reg];
                            o_reg[1] <= p_reg[1];
                            o_reg[2] <= (piece_reg == 2'd1) ? v_reg[c_reg] : v_reg[c2];
                        end
                    end
            endcase
        end
    end

    assign res.valid = out_valid_reg;
    assign res.out_v0_x = o_reg[0][0];
    assign res.out_v0_y = o_reg[0][1];
    assign res.out_v0_z = o_reg[0][2];
    assign res.out_v1_x = o_reg[1][0];
    assign res.out_v1_y = o_reg[1][1];
    assign res.out_v1_z = o_reg[1][2];
    assign res.out_v2_x = o_reg[2][0];
    assign res.out_v2_y = o_reg[2][1];
    assign res.out_v2_z = o_reg[2][2];
    assign res.upper_side = o_upper_reg;
    assign res.status = o_status_reg;
    assign res.last_piece = o_last_reg;

    `TPS_ASSERT_NEXT(a_hold, clk, rst_n, res.valid && !res.ready, res.valid)
    `TPS_ASSERT(a_idle_only, clk, rst_n, !in_ready || state_reg == tps_pkg::BK_IDLE)
    `TPS_ASSERT(a_whole_last, clk, rst_n,
        !(res.valid && res.status != tps_pkg::ST_SPLIT) || res.last_piece)
endmodule
`default_nettype wire

>>> hdl/triangle_plane_split.sv
// Top level of the triangle plane split block.
// Usage:
// A triangle beat enters on tri_in; result pieces leave on pieces_out, one beat
// per piece, with last_piece set on the final piece of each triangle.
// Plane registers are written through cfg_in, index 0 to 4, while idle; this
// binds the user, as the block itself does not enforce it. The front end takes
// a triangle each cycle unless held by back-pressure and classifies it in its
// product and distance stages. A two-entry queue decouples it from the back
// end. An unsplit triangle passes the back end through its idle and emit
// states, and the back end takes the next triangle only once back in idle.
// A split triangle runs a one-bit-per-cycle divider of 30 steps and the single
// interpolation multiplier for one crossing point when it gives two pieces and
// for two crossing points when it gives three, holding the back end meanwhile.
// Reset restores the default plane and empties all stages.
// When the receiver stalls, the held piece stays stable and the queue and
// front end fill, then tri_in.ready drops.
`default_nettype none
module triangle_plane_split #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    tps_cfg_if.sink cfg_in,
    tps_tri_if.sink tri_in,
    tps_piece_if.source pieces_out
);
    localparam int QW = 9*COORD_WIDTH + 3*tps_pkg::DIST_W + 6 + 2 + 3;

    tps_pkg::plane_cfg_t cfg_reg;
    assign cfg_in.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx <= 16'd16384;
            cfg_reg.ny <= 16'd0;
            cfg_reg.nz <= 16'd0;
            cfg_reg.off <= 32'd0;
            cfg_reg.band <= 16'd1;
        end
        else if (cfg_in.valid)
        begin
            case (cfg_in.index)
                tps_pkg::REG_NX:   cfg_reg.nx <= cfg_in.data[15:0];
                tps_pkg::REG_NY:   cfg_reg.ny <= cfg_in.data[15:0];
                tps_pkg::REG_NZ:   cfg_reg.nz <= cfg_in.data[15:0];
                tps_pkg::REG_OFF:  cfg_reg.off <= cfg_in.data;
                tps_pkg::REG_BAND: cfg_reg.band <= cfg_in.data[15:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready;
    logic [9*COORD_WIDTH-1:0] f_verts, b_verts;
    logic [3*tps_pkg::DIST_W-1:0] f_dist, b_dist;
    logic [5:0] f_sides, b_sides;
    tps_pkg::kind_t f_kind, b_kind;
    tps_pkg::status_t f_status, b_status;
    logic b_valid, b_ready;
    logic [QW-1:0] q_out;

    tps_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(tri_in.valid), .in_ready(tri_in.ready),
        .in_verts({tri_in.v2_z, tri_in.v2_y, tri_in.v2_x, tri_in.v1_z, tri_in.v1_y,
                   tri_in.v1_x, tri_in.v0_z, tri_in.v0_y, tri_in.v0_x}),
        .in_fn({tri_in.face_normal_z, tri_in.face_normal_y, tri_in.face_normal_x}),
        .out_valid(f_valid), .out_ready(f_ready), .out_verts(f_verts),
        .out_dist(f_dist), .out_sides(f_sides), .out_kind(f_kind),
        .out_status(f_status)
    );

    tps_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready),
        .in_data({f_verts, f_dist, f_sides, f_kind, f_status}),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(q_out)
    );

    assign {b_verts, b_dist, b_sides} = q_out[QW-1:5];
    assign b_kind = tps_pkg::kind_t'(q_out[4:3]);
    assign b_status = tps_pkg::status_t'(q_out[2:0]);

    tps_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_ready(b_ready), .in_verts(b_verts),
        .in_dist(b_dist), .in_sides(b_sides), .in_kind(b_kind),
        .in_status(b_status), .res(pieces_out)
    );
endmodule
`default_nettype wire

>>> tb/sv/triangle_plane_split_tb.sv
// Self-checking testbench for the triangle plane split: directed table, then random triangles.
`default_nettype none
module triangle_plane_split_tb;
    typedef logic signed [31:0] coord_t;
    typedef coord_t vert_t [3];

    typedef struct {
        coord_t v [9];
        logic signed [15:0] fn [3];
    } tri_t;

    typedef struct {
        coord_t v [9];
        logic upper;
        tps_pkg::status_t status;
        logic last;
    } piece_t;

    typedef struct {
        tri_t t;
        logic has_exp;
        tps_pkg::status_t exp_status;
    } row_t;

    localparam coord_t ONE = 32'sh00010000;
    localparam coord_t MX = 32'sh7fffffff;
    localparam coord_t MN = 32'sh80000000;

    logic clk;
    logic rst_n;
    tps_cfg_if cfg_ch ();
    tps_tri_if tri_ch ();
    tps_piece_if piece_ch ();

    triangle_plane_split dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_in(cfg_ch.sink),
        .tri_in(tri_ch.sink),
        .pieces_out(piece_ch.source)
    );

    logic signed [15:0] pl_nx, pl_ny, pl_nz;
    logic signed [31:0] pl_off;
    logic [15:0] pl_band;

    piece_t expected_pieces [$];
    row_t dir_rows [$];
    string coord_names [9] = '{"out_v0_x", "out_v0_y", "out_v0_z", "out_v1_x", "out_v1_y",
                               "out_v1_z", "out_v2_x", "out_v2_y", "out_v2_z"};
    int fail_count;
    logic tri_gaps_on;
    logic piece_stalls_on;
    int hold_off_cycles;
    int idle_left = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [63:0] plane_distance(coord_t x, coord_t y, coord_t z);
        logic signed [63:0] s;
        s = 64'(x) * 64'(pl_nx) + 64'(y) * 64'(pl_ny) + 64'(z) * 64'(pl_nz)
            + (64'(pl_off) <<< tps_pkg::NORM_FRAC);
        return s;
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic coord_t crossing_coord(coord_t a, coord_t b, logic [63:0] alpha);
        logic signed [63:0] diff;
        logic [127:0] prod;
        logic [63:0] q;
        diff = 64'(b) - 64'(a);
        prod = 128'(magnitude(diff)) * 128'(alpha);
        q = 64'(prod >> tps_pkg::ALPHA_FRAC) + 64'(prod[tps_pkg::ALPHA_FRAC-1]);
        if (diff < 0)
            return coord_t'(64'(a) - q);
        return coord_t'(64'(a) + q);
    endfunction

    function automatic vert_t crossing_point(vert_t a, vert_t b, logic signed [63:0] da,
                                             logic signed [63:0] db);
        logic [127:0] num;
        logic [63:0] alpha;
        vert_t p;
        num = 128'(magnitude(da)) << tps_pkg::ALPHA_FRAC;
        alpha = 64'(num / 128'(magnitude(da) + magnitude(db)));
        for (int k = 0; k < 3; k++)
            p[k] = crossing_coord(a[k], b[k], alpha);
        return p;
    endfunction

    function automatic logic [127:0] squared_length(vert_t p, vert_t q);
        logic [127:0] s;
        logic [63:0] m;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            m = magnitude(64'(p[k]) - 64'(q[k]));
            s += 128'(m) * 128'(m);
        end
        return s;
    endfunction

    task automatic push_piece(vert_t a, vert_t b, vert_t c, logic up, tps_pkg::status_t st,
                              logic last);
        piece_t p;
        for (int k = 0; k < 3; k++)
        begin
            p.v[k] = a[k];
            p.v[3 + k] = b[k];
            p.v[6 + k] = c[k];
        end
        p.upper = up;
        p.status = st;
        p.last = last;
        expected_pieces.insert(expected_pieces.size(), p);
    endtask

    task automatic predict_split(tri_t t);
        vert_t vx [3];
        vert_t pt [2];
        logic signed [63:0] vdist [3];
        tps_pkg::side_t side [3];
        logic signed [63:0] band;
        logic any_above, any_below;
        int edge_no [2];
        int cnt, c, c1, c2, j, n;
        tps_pkg::status_t st;
        logic signed [63:0] dot;
        band = 64'(pl_band) <<< tps_pkg::NORM_FRAC;
        any_above = 0;
        any_below = 0;
        cnt = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                vx[i][k] = t.v[i * 3 + k];
            vdist[i] = plane_distance(vx[i][0], vx[i][1], vx[i][2]);
            if (vdist[i] > band)
            begin
                side[i] = tps_pkg::SIDE_ABOVE;
                any_above = 1;
            end
            else if (vdist[i] < -band)
            begin
                side[i] = tps_pkg::SIDE_BELOW;
                any_below = 1;
            end
            else
                side[i] = tps_pkg::SIDE_ON;
        end
        if (!(any_above && any_below))
        begin
            if (any_below)
                st = tps_pkg::ST_BELOW;
            else if (any_above)
                st = tps_pkg::ST_ABOVE;
            else
            begin
                dot = 64'(t.fn[0]) * 64'(pl_nx) + 64'(t.fn[1]) * 64'(pl_ny)
                    + 64'(t.fn[2]) * 64'(pl_nz);
                st = dot < 0 ? tps_pkg::ST_COP_OPP : tps_pkg::ST_COP_SAME;
            end
            push_piece(vx[0], vx[1], vx[2], st == tps_pkg::ST_ABOVE, st, 1'b1);
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            n = (i + 1) % 3;
            if (cnt < 2 && side[i] != tps_pkg::SIDE_ON && side[n] != tps_pkg::SIDE_ON
                && side[i] != side[n])
            begin
                pt[cnt] = crossing_point(vx[i], vx[n], vdist[i], vdist[n]);
                edge_no[cnt] = i;
                cnt++;
            end
        end
        if (cnt == 1)
        begin
            c = edge_no[0];
            c1 = (c + 1) % 3;
            c2 = (c + 2) % 3;
            push_piece(pt[0], vx[c1], vx[c2], side[c1] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b0);
            push_piece(pt[0], vx[c2], vx[c], side[c] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b1);
            return;
        end
        if ((edge_no[0] + 1) % 3 == edge_no[1])
        begin
            c = edge_no[0];
            j = 0;
        end
        else
        begin
            c = edge_no[1];
            j = 1;
        end
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        push_piece(pt[j], vx[c1], pt[1 - j], side[c1] == tps_pkg::SIDE_ABOVE,
                   tps_pkg::ST_SPLIT, 1'b0);
        if (squared_length(pt[j], vx[c2]) < squared_length(pt[1 - j], vx[c]))
        begin
            push_piece(pt[j], pt[1 - j], vx[c2], side[c2] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b0);
            push_piece(pt[j], vx[c2], vx[c], side[c2] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b1);
        end
        else
        begin
            push_piece(pt[j], pt[1 - j], vx[c], side[c] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b0);
            push_piece(vx[c], pt[1 - j], vx[c2], side[c] == tps_pkg::SIDE_ABOVE,
                       tps_pkg::ST_SPLIT, 1'b1);
        end
    endtask

    task automatic write_plane_reg(tps_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            tps_pkg::REG_NX: pl_nx = value[15:0];
            tps_pkg::REG_NY: pl_ny = value[15:0];
            tps_pkg::REG_NZ: pl_nz = value[15:0];
            tps_pkg::REG_OFF: pl_off = value;
            tps_pkg::REG_BAND: pl_band = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [31:0] off, logic [15:0] band);
        write_plane_reg(tps_pkg::REG_NX, 32'(nx));
        write_plane_reg(tps_pkg::REG_NY, 32'(ny));
        write_plane_reg(tps_pkg::REG_NZ, 32'(nz));
        write_plane_reg(tps_pkg::REG_OFF, off);
        write_plane_reg(tps_pkg::REG_BAND, 32'(band));
        cfg_ch.valid <= 0;
    endtask

    task automatic drain_pieces();
        while (expected_pieces.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_triangle(tri_t t);
        int gap;
        if (tri_gaps_on && $urandom_range(3) == 0)
        begin
            tri_ch.valid <= 0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        tri_ch.valid <= 1;
        tri_ch.v0_x <= t.v[0];
        tri_ch.v0_y <= t.v[1];
        tri_ch.v0_z <= t.v[2];
        tri_ch.v1_x <= t.v[3];
        tri_ch.v1_y <= t.v[4];
        tri_ch.v1_z <= t.v[5];
        tri_ch.v2_x <= t.v[6];
        tri_ch.v2_y <= t.v[7];
        tri_ch.v2_z <= t.v[8];
        tri_ch.face_normal_x <= t.fn[0];
        tri_ch.face_normal_y <= t.fn[1];
        tri_ch.face_normal_z <= t.fn[2];
        do @(posedge clk); while (!tri_ch.ready);
        predict_split(t);
    endtask

    task automatic end_triangles();
        tri_ch.valid <= 0;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return coord_t'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
        endcase
    endfunction

    function automatic tri_t rand_triangle();
        tri_t t;
        for (int i = 0; i < 9; i++)
            t.v[i] = rand_coord();
        for (int i = 0; i < 3; i++)
            t.fn[i] = 16'($urandom);
        if ($urandom_range(4) == 0)
        begin
            // Put one vertex's x at minus the offset, on a plane along x, for the two-piece path.
            t.v[3 * $urandom_range(2)] = -pl_off;
        end
        return t;
    endfunction

    function automatic tri_t make_tri(coord_t a0, coord_t a1, coord_t a2, coord_t b0, coord_t b1,
                                      coord_t b2, coord_t c0, coord_t c1, coord_t c2,
                                      logic signed [15:0] f0);
        tri_t t;
        t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        t.fn = '{f0, 16'sd0, 16'sd0};
        return t;
    endfunction

    task automatic add_row(tri_t t, logic has_exp, tps_pkg::status_t exp_status);
        row_t r;
        r.t = t;
        r.has_exp = has_exp;
        r.exp_status = exp_status;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                piece_ch.ready <= 0;
            end
            else if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                piece_ch.ready <= 0;
            end
            else if (piece_stalls_on && $urandom_range(3) == 0)
            begin
                idle_left <= $urandom_range(0, 11);
                piece_ch.ready <= 0;
            end
            else
                piece_ch.ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        piece_t exp_p;
        coord_t got [9];
        if (rst_n && piece_ch.valid && piece_ch.ready)
        begin
            got = '{piece_ch.out_v0_x, piece_ch.out_v0_y, piece_ch.out_v0_z,
                    piece_ch.out_v1_x, piece_ch.out_v1_y, piece_ch.out_v1_z,
                    piece_ch.out_v2_x, piece_ch.out_v2_y, piece_ch.out_v2_z};
            if (expected_pieces.size() == 0)
            begin
                $error("unexpected piece beat");
                fail_count++;
            end
            else
            begin
                exp_p = expected_pieces.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== exp_p.v[i])
                    begin
                        $error("%s: expected %0d, actual %0d", coord_names[i], exp_p.v[i],
                               got[i]);
                        fail_count++;
                    end
                if (piece_ch.upper_side !== exp_p.upper)
                begin
                    $error("upper_side: expected %0d, actual %0d", exp_p.upper,
                           piece_ch.upper_side);
                    fail_count++;
                end
                if (piece_ch.status !== exp_p.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_p.status, piece_ch.status);
                    fail_count++;
                end
                if (piece_ch.last_piece !== exp_p.last)
                begin
                    $error("last_piece: expected %0d, actual %0d", exp_p.last,
                           piece_ch.last_piece);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        tri_gaps_on = 1;
        piece_stalls_on = 1;
        hold_off_cycles = 0;
        rst_n = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        tri_ch.valid = 0;
        {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y, tri_ch.v1_z} = '0;
        {tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} = '0;
        {tri_ch.face_normal_x, tri_ch.face_normal_y, tri_ch.face_normal_z} = '0;
        piece_ch.ready = 0;
        pl_nx = 16384;
        pl_ny = 0;
        pl_nz = 0;
        pl_off = 0;
        pl_band = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed rows under the reset plane x = 0.
        add_row(make_tri(-ONE, 0, 0, -ONE, ONE, 0, -ONE, 0, ONE, 16'sd0), 1, tps_pkg::ST_BELOW);
        add_row(make_tri(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, 16'sd0), 1, tps_pkg::ST_ABOVE);
        add_row(make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 16'sd16384), 1, tps_pkg::ST_COP_SAME);
        add_row(make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE, -16'sd16384), 1, tps_pkg::ST_COP_OPP);
        add_row(make_tri(0, MX, MN, 0, MN, MX, 0, 0, 0, 16'sh8000), 1, tps_pkg::ST_COP_OPP);
        add_row(make_tri(MX, MX, MX, MX, MN, MN, ONE, 0, 0, 16'sh7fff), 1, tps_pkg::ST_ABOVE);
        add_row(make_tri(MN, MX, MN, MN, MN, MX, -1, 0, 0, 16'sd0), 1, tps_pkg::ST_BELOW);
        add_row(make_tri(-ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(0, ONE, 0, -ONE, 0, 0, ONE, 0, 0, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(-ONE, 0, 0, ONE, 0, 0, ONE, ONE, 0, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(ONE, 0, 0, -ONE, 0, 0, -ONE, 4 * ONE, ONE, 16'sd0), 0,
                tps_pkg::ST_SPLIT);
        add_row(make_tri(MN, MN, MN, MX, MX, MX, MX, MN, 0, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(MX, 0, 0, MN, 0, 0, 0, MX, MN, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(2, 0, 0, -3, ONE, 0, 5, 0, ONE, 16'sd0), 0, tps_pkg::ST_SPLIT);
        add_row(make_tri(1, 0, 0, -1, 0, 0, 0, ONE, 0, 16'sd0), 1, tps_pkg::ST_COP_SAME);
        foreach (dir_rows[r])
        begin
            send_triangle(dir_rows[r].t);
            if (dir_rows[r].has_exp && expected_pieces[$].status != dir_rows[r].exp_status)
            begin
                $error("status of directed row %0d: expected %0d, actual %0d", r,
                       dir_rows[r].exp_status, expected_pieces[$].status);
                fail_count++;
            end
        end
        end_triangles();
        drain_pieces();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_plane(16'h8000, 16'h7fff, 16'h8000, 32'h7fffffff, 16'hffff);
                1: set_plane(16'h4000, 16'h0000, 16'h0000, 32'h80000000, 16'h0000);
                2: set_plane(16'h2d41, 16'hd2bf, 16'h0000, 32'h00010000, 16'h0010);
                default: set_plane(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                                   16'($urandom_range(0, 64)));
            endcase
            if (phase == 1)
            begin
                hold_off_cycles <= 400;
                @(posedge clk);
            end
            tri_gaps_on = (phase != 4);
            piece_stalls_on = (phase != 4);
            for (int i = 0; i < 90; i++)
                send_triangle(rand_triangle());
            end_triangles();
            drain_pieces();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
